// ===== src/chm_pkg.sv =====
// chained hash map package: field widths, request mode codes and the
// command / status structs between the controller and the datapath
// no dependencies
package chm_pkg;

  localparam int MODE_W = 2;
  localparam int KEY_W  = 64;
  localparam int VAL_W  = 64;
  localparam int EXP_W  = 4;

  localparam logic [EXP_W-1:0] BUCKET_EXP_RESET = 4'd10;

  // request modes; the fourth code does nothing and answers with zeros
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HEAD_WAIT,
    S_ENTRY_RD,
    S_ENTRY_WAIT,
    S_UNLINK,
    S_FREE,
    S_INS_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic accept;
    logic clear_step;
    logic load_head;
    logic entry_rd;
    logic step;
    logic hit;
    logic unlink;
    logic free;
    logic insert;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic              cur_null;
    logic              key_match;
    logic              clear_last;
    logic              out_free;
    logic [MODE_W-1:0] op_mode;
  } sts_t;

endpackage

// ===== src/chm_ifs.sv =====
// handshake interfaces of the chained hash map: request, response and
// configuration channels
// depends on chm_pkg
interface chm_req_if;
  import chm_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [KEY_W-1:0]  key;
  logic [VAL_W-1:0]  value;
  modport source (output valid, output mode, output key, output value, input ready);
  modport sink   (input valid, input mode, input key, input value, output ready);
endinterface

interface chm_rsp_if;
  import chm_pkg::*;
  logic             valid;
  logic             ready;
  logic             found;
  logic [VAL_W-1:0] result_value;
  logic             pool_full;
  modport source (output valid, output found, output result_value, output pool_full,
                  input ready);
  modport sink   (input valid, input found, input result_value, input pool_full,
                  output ready);
endinterface

interface chm_cfg_if;
  import chm_pkg::*;
  logic             valid;
  logic             ready;
  logic [EXP_W-1:0] bucket_exp;
  modport source (output valid, output bucket_exp, input ready);
  modport sink   (input valid, input bucket_exp, output ready);
endinterface

// ===== src/chm_ctrl.sv =====
// chained hash map controller: state machine sequencing clear sweeps,
// chain walks, unlinking and inserts
// depends on chm_pkg
module chm_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  input  logic [chm_pkg::MODE_W-1:0] req_mode,
  input  logic                       cfg_fire,
  input  chm_pkg::sts_t              sts,
  output chm_pkg::cmd_t              cmd
);
  import chm_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else if (cfg_fire) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          if (req_mode == MODE_LOOKUP || req_mode == MODE_DELETE) begin
            state_next = S_HEAD_WAIT;
          end else if (req_mode == MODE_INSERT) begin
            state_next = S_INS_WAIT;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_HEAD_WAIT:  state_next = S_ENTRY_RD;
      S_ENTRY_RD: begin
        state_next = sts.cur_null ? S_DONE : S_ENTRY_WAIT;
      end
      S_ENTRY_WAIT: begin
        if (!sts.key_match) begin
          state_next = S_ENTRY_RD;
        end else if (sts.op_mode == MODE_DELETE) begin
          state_next = S_UNLINK;
        end else begin
          state_next = S_DONE;
        end
      end
      S_UNLINK:     state_next = S_FREE;
      S_FREE:       state_next = S_DONE;
      S_INS_WAIT:   state_next = S_DONE;
      S_DONE: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default:      state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      S_CLEAR:      cmd.clear_step = 1'b1;
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.accept   = req_valid;
      end
      S_HEAD_WAIT:  cmd.load_head = 1'b1;
      S_ENTRY_RD:   cmd.entry_rd  = !sts.cur_null;
      S_ENTRY_WAIT: begin
        cmd.hit  = sts.key_match;
        cmd.step = !sts.key_match;
      end
      S_UNLINK:     cmd.unlink = 1'b1;
      S_FREE:       cmd.free   = 1'b1;
      S_INS_WAIT:   cmd.insert = 1'b1;
      S_DONE:       cmd.emit   = sts.out_free;
      default:      cmd = '0;
    endcase
  end

  a_emit_from_done: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> state == S_IDLE || state == S_CLEAR)
    else $error("emit did not return to idle");
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |-> cmd.in_ready && req_valid)
    else $error("accept outside idle");
  a_hit_needs_match: assert property (@(posedge clk) disable iff (rst)
    (cmd.hit || cmd.step) |-> $past(cmd.entry_rd))
    else $error("compare without an entry read");

endmodule

// ===== src/chm_datapath.sv =====
// chained hash map datapath: bucket head, key, value and link memories,
// free list, walk registers and the response register
// depends on chm_pkg
module chm_datapath #(
  parameter int MAX_BUCKET_BITS = 10,
  parameter int POOL_ENTRIES    = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  chm_pkg::cmd_t              cmd,
  output chm_pkg::sts_t              sts,
  input  logic [chm_pkg::MODE_W-1:0] req_mode,
  input  logic [chm_pkg::KEY_W-1:0]  req_key,
  input  logic [chm_pkg::VAL_W-1:0]  req_value,
  input  logic                       cfg_fire,
  input  logic [chm_pkg::EXP_W-1:0]  cfg_bucket_exp,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output logic                       rsp_found,
  output logic [chm_pkg::VAL_W-1:0]  rsp_result_value,
  output logic                       rsp_pool_full
);
  import chm_pkg::*;

  localparam int NBUCKETS = 1 << MAX_BUCKET_BITS;
  localparam int IDX_W    = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int LINK_W   = $clog2(POOL_ENTRIES + 1);
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_ENTRIES);

  // memories
  logic [LINK_W-1:0] head_mem  [NBUCKETS];
  logic [KEY_W-1:0]  key_mem   [POOL_ENTRIES];
  logic [VAL_W-1:0]  value_mem [POOL_ENTRIES];
  logic [LINK_W-1:0] link_mem  [POOL_ENTRIES];

  logic [LINK_W-1:0] head_rd;
  logic [KEY_W-1:0]  key_rd;
  logic [VAL_W-1:0]  value_rd;
  logic [LINK_W-1:0] link_rd;

  // control state
  logic [EXP_W-1:0]           bucket_exp;
  logic [MAX_BUCKET_BITS-1:0] clr_cnt;
  logic [LINK_W-1:0]          free_head;
  logic [LINK_W-1:0]          never_used;
  logic                       out_valid;

  // operation registers
  logic [MODE_W-1:0]          op_mode;
  logic [KEY_W-1:0]           op_key;
  logic [VAL_W-1:0]           op_value;
  logic [MAX_BUCKET_BITS-1:0] op_bucket;
  logic [LINK_W-1:0]          cur;
  logic [LINK_W-1:0]          prev;
  logic                       res_found;
  logic [VAL_W-1:0]           res_value;
  logic                       res_full;
  logic                       out_found;
  logic [VAL_W-1:0]           out_value;
  logic                       out_full;

  // bucket of the incoming key: low bucket_exp bits, saturating at the table size
  logic [MAX_BUCKET_BITS-1:0] exp_sel;
  logic [MAX_BUCKET_BITS-1:0] req_bucket;

  always_comb begin
    for (int i = 0; i < MAX_BUCKET_BITS; i++) begin
      exp_sel[i] = (i < int'(bucket_exp));
    end
    req_bucket = req_key[MAX_BUCKET_BITS-1:0] & exp_sel;
  end

  // allocation choice for insert
  logic              free_avail;
  logic              fresh_avail;
  logic              ins_ok;
  logic [LINK_W-1:0] slot;

  assign free_avail  = (free_head != NULL_LINK);
  assign fresh_avail = (never_used != NULL_LINK);
  assign ins_ok      = free_avail || fresh_avail;
  assign slot        = free_avail ? free_head : never_used;

  // memory port selection
  logic                       head_we;
  logic [MAX_BUCKET_BITS-1:0] head_wa;
  logic [LINK_W-1:0]          head_wd;
  logic                       link_we;
  logic [IDX_W-1:0]           link_wa;
  logic [LINK_W-1:0]          link_wd;
  logic [IDX_W-1:0]           link_ra;
  logic                       entry_we;
  logic                       link_re;

  always_comb begin
    head_we  = 1'b0;
    head_wa  = op_bucket;
    head_wd  = NULL_LINK;
    link_we  = 1'b0;
    link_wa  = slot[IDX_W-1:0];
    link_wd  = head_rd;
    entry_we = 1'b0;
    priority if (cmd.clear_step) begin
      head_we = 1'b1;
      head_wa = clr_cnt;
    end else if (cmd.insert) begin
      head_we  = ins_ok;
      head_wd  = slot;
      link_we  = ins_ok;
      entry_we = ins_ok;
    end else if (cmd.unlink) begin
      head_we = (prev == NULL_LINK);
      head_wd = link_rd;
      link_we = (prev != NULL_LINK);
      link_wa = prev[IDX_W-1:0];
      link_wd = link_rd;
    end else if (cmd.free) begin
      link_we = 1'b1;
      link_wa = cur[IDX_W-1:0];
      link_wd = free_head;
    end
    link_re = cmd.accept || cmd.entry_rd;
    link_ra = cmd.accept ? free_head[IDX_W-1:0] : cur[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (cmd.accept) head_rd <= head_mem[req_bucket];
  end

  always_ff @(posedge clk) begin
    if (entry_we) begin
      key_mem[slot[IDX_W-1:0]]   <= op_key;
      value_mem[slot[IDX_W-1:0]] <= op_value;
    end
    if (cmd.entry_rd) begin
      key_rd   <= key_mem[cur[IDX_W-1:0]];
      value_rd <= value_mem[cur[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    if (link_re) link_rd <= link_mem[link_ra];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_exp <= BUCKET_EXP_RESET;
      clr_cnt    <= '0;
      free_head  <= NULL_LINK;
      never_used <= '0;
    end else if (cfg_fire) begin
      bucket_exp <= cfg_bucket_exp;
      clr_cnt    <= '0;
      free_head  <= NULL_LINK;
      never_used <= '0;
    end else begin
      if (cmd.clear_step) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.insert && free_avail) begin
        free_head <= link_rd;
      end else if (cmd.insert && fresh_avail) begin
        never_used <= never_used + LINK_W'(1);
      end
      if (cmd.free) free_head <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (rsp_ready) begin
      out_valid <= 1'b0;
    end
  end

  // operation and walk registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_mode   <= req_mode;
      op_key    <= req_key;
      op_value  <= req_value;
      op_bucket <= req_bucket;
      res_found <= 1'b0;
      res_value <= '0;
      res_full  <= 1'b0;
    end
    if (cmd.load_head) begin
      cur  <= head_rd;
      prev <= NULL_LINK;
    end
    if (cmd.step) begin
      prev <= cur;
      cur  <= link_rd;
    end
    if (cmd.hit) begin
      res_found <= 1'b1;
      res_value <= value_rd;
    end
    if (cmd.insert) res_full <= !ins_ok;
    if (cmd.emit) begin
      out_found <= res_found;
      out_value <= res_value;
      out_full  <= res_full;
    end
  end

  assign sts.cur_null   = (cur == NULL_LINK);
  assign sts.key_match  = (key_rd == op_key);
  assign sts.clear_last = (clr_cnt == {MAX_BUCKET_BITS{1'b1}});
  assign sts.out_free   = !out_valid || rsp_ready;
  assign sts.op_mode    = op_mode;

  assign rsp_valid        = out_valid;
  assign rsp_found        = out_found;
  assign rsp_result_value = out_value;
  assign rsp_pool_full    = out_full;

  a_never_used_bound: assert property (@(posedge clk) disable iff (rst)
    never_used <= NULL_LINK)
    else $error("fresh entry count beyond pool");
  a_free_head_bound: assert property (@(posedge clk) disable iff (rst)
    free_head <= NULL_LINK)
    else $error("free list head out of range");
  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !out_valid || rsp_ready)
    else $error("response overwritten before taken");
  a_cfg_restarts_clear: assert property (@(posedge clk) disable iff (rst)
    cfg_fire |=> clr_cnt == '0 && free_head == NULL_LINK)
    else $error("configuration write did not empty the table");

endmodule

// ===== src/chained_hash_map.sv =====
// chained hash map top level: channel wiring of controller and datapath
// depends on chm_pkg, chm_ifs, chm_ctrl, chm_datapath
//
// channel  role    fields                          transaction when
// req      sink    mode, key, value                req.valid && req.ready
// rsp      source  found, result_value, pool_full  rsp.valid && rsp.ready
// cfg      sink    bucket_exp                      cfg.valid && cfg.ready
//
// request flow: lookup and delete load the bucket head and walk the chain, where
// every chain entry costs one registered read of the key / value / link memories
// plus a compare; a delete hit then unlinks and frees the entry
// reset and every bucket_exp write start a clearing pass over the bucket
// head memory, during which req.ready stays low
// a finished response waits in its own register, so the next request is
// taken while rsp is stalled; only a second response waits for it
module chained_hash_map #(
  parameter int MAX_BUCKET_BITS = 10,
  parameter int POOL_ENTRIES    = 1024
) (
  input logic   clk,
  input logic   rst,
  chm_req_if.sink   req,
  chm_rsp_if.source rsp,
  chm_cfg_if.sink   cfg
);
  import chm_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic cfg_fire;

  // configuration writes are always taken; the source must send them only while idle, the block does not enforce it
  assign cfg.ready = 1'b1;
  assign cfg_fire  = cfg.valid;

  // requests only enter in the idle state, one at a time
  assign req.ready = cmd.in_ready;

  chm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_mode  (req.mode),
    .cfg_fire  (cfg_fire),
    .sts       (sts),
    .cmd       (cmd)
  );

  chm_datapath #(
    .MAX_BUCKET_BITS (MAX_BUCKET_BITS),
    .POOL_ENTRIES    (POOL_ENTRIES)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .req_mode         (req.mode),
    .req_key          (req.key),
    .req_value        (req.value),
    .cfg_fire         (cfg_fire),
    .cfg_bucket_exp   (cfg.bucket_exp),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_found        (rsp.found),
    .rsp_result_value (rsp.result_value),
    .rsp_pool_full    (rsp.pool_full)
  );

endmodule
